// File: hdl/power_of_two_box_downscaler_assert.svh
// Assertion macros used by the back module of the downscaler.
`ifndef POWER_OF_TWO_BOX_DOWNSCALER_ASSERT_SVH
`define POWER_OF_TWO_BOX_DOWNSCALER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define P2BD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define P2BD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/p2bd_pkg.sv
// Shared types and constants of the power-of-two box downscaler.
package p2bd_pkg;

  localparam int DIM_W      = 12;                 // width of size registers and counters
  localparam int DIM_MAX    = (1 << DIM_W) - 1;   // largest size a register can hold
  localparam int FACTOR_W   = 3;
  localparam int CFG_W      = 12;                 // widest register
  localparam int CFG_IDX_W  = 2;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 4 * CHAN_W;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT_DEF  = 2048;
  localparam int MAX_FACTOR_DEF  = 7;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [FACTOR_W-1:0] SHIFT_FACTOR_RST = 3'd1;
  localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_FACTOR = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_ALPHA_ENABLE = 2'd3
  } p2bd_reg_t;

  // One classified pixel, passed from front to back.
  typedef struct packed {
    logic [DIM_W-1:0]  col_idx;    // output column
    logic [CHAN_W-1:0] red;        // contributions already scaled
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              alpha_en;
    logic              emit;       // bottom-right pixel of its block
    logic              last;       // last block of the frame
  } p2bd_item_t;

  localparam int ITEM_W = $bits(p2bd_item_t);

endpackage

// File: hdl/p2bd_ram.sv
// Generic simple dual-port RAM with registered read.
module p2bd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/p2bd_fifo.sv
// Short queue between front and back.
module p2bd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/p2bd_front.sv
// Front: configuration registers, raster position and pixel classification.
module p2bd_front #(
  parameter int MAX_WIDTH  = p2bd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = p2bd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FACTOR = p2bd_pkg::MAX_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [p2bd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [p2bd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [p2bd_pkg::PIX_W-1:0]     s_tdata,
  input  logic                           clearing,
  input  logic                           queue_full,
  output logic                           push,
  output p2bd_pkg::p2bd_item_t           item
);

  import p2bd_pkg::*;

  localparam int FACTOR_CAP = (MAX_FACTOR > 7) ? 7 : MAX_FACTOR;
  localparam int WIDTH_CAP  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int HEIGHT_CAP = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;

  logic [FACTOR_W-1:0] shift_factor;
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic                alpha_enable;
  logic [DIM_W-1:0]    col;
  logic [DIM_W-1:0]    row;

  logic [FACTOR_W-1:0] fac;
  logic [DIM_W-1:0]    w;
  logic [DIM_W-1:0]    h;
  logic [DIM_W-1:0]    mask;
  logic [DIM_W-1:0]    bx;
  logic [DIM_W-1:0]    by;
  logic [DIM_W-1:0]    w_out;
  logic [DIM_W-1:0]    h_out;
  logic [FACTOR_W:0]   csh;
  logic [DIM_W:0]      col_inc;
  logic [DIM_W:0]      row_inc;
  logic                active;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_factor <= SHIFT_FACTOR_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      alpha_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (p2bd_reg_t'(cfg_index))
        REG_SHIFT_FACTOR: shift_factor <= cfg_data[FACTOR_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_ALPHA_ENABLE: alpha_enable <= cfg_data[0];
      endcase
    end
  end

  // Clamp factor and sizes into their legal ranges.
  always_comb begin
    fac = (32'(shift_factor) > FACTOR_CAP) ? FACTOR_W'(FACTOR_CAP) : shift_factor;
    priority if (image_width == '0)               w = DIM_W'(1);
    else if (32'(image_width) > WIDTH_CAP)        w = DIM_W'(WIDTH_CAP);
    else                                          w = image_width;
    priority if (image_height == '0)              h = DIM_W'(1);
    else if (32'(image_height) > HEIGHT_CAP)      h = DIM_W'(HEIGHT_CAP);
    else                                          h = image_height;
  end

  assign mask    = ~({DIM_W{1'b1}} << fac);
  assign bx      = col >> fac;
  assign by      = row >> fac;
  assign w_out   = w >> fac;
  assign h_out   = h >> fac;
  assign csh     = {fac, 1'b1};
  assign active  = (bx < w_out) && (by < h_out);
  assign col_inc = {1'b0, col} + 1'b1;
  assign row_inc = {1'b0, row} + 1'b1;

  assign s_tready = !clearing && !queue_full;
  assign push     = s_tvalid && s_tready && active;

  always_comb begin
    item.col_idx  = bx;
    item.red      = CHAN_W'({s_tdata[7:0],   1'b1} >> csh);
    item.green    = CHAN_W'({s_tdata[15:8],  1'b1} >> csh);
    item.blue     = CHAN_W'({s_tdata[23:16], 1'b1} >> csh);
    item.alpha    = s_tdata[31:24] >> {fac, 1'b0};
    item.alpha_en = alpha_enable;
    item.emit     = ((col & mask) == mask) && ((row & mask) == mask);
    item.last     = (bx == w_out - 1'b1) && (by == h_out - 1'b1);
  end

  // Advance the raster position on every accepted pixel, dropped or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (s_tvalid && s_tready) begin
      if (col_inc >= {1'b0, w}) begin
        col <= '0;
        row <= (row_inc >= {1'b0, h}) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col <= col_inc[DIM_W-1:0];
      end
    end
  end

endmodule

// File: hdl/p2bd_back.sv
// Back: column accumulator read-modify-write, clearing sweep and output register.
`include "power_of_two_box_downscaler_assert.svh"

module p2bd_back #(
  parameter int MAX_WIDTH = p2bd_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       clearing,
  input  logic                       queue_valid,
  input  p2bd_pkg::p2bd_item_t       queue_head,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [p2bd_pkg::PIX_W-1:0] m_tdata,
  output logic                       m_tlast
);

  import p2bd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             s1_valid;
  p2bd_item_t       s1_item;
  logic [AW-1:0]    s1_addr;
  logic             out_free;
  logic             s1_done;
  logic             s1_load;
  logic [AW-1:0]    clr_cnt;
  logic             fw_valid;
  logic [AW-1:0]    fw_addr;
  logic [PIX_W-1:0] fw_data;
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] acc;
  logic [PIX_W-1:0] sum;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [PIX_W-1:0] wdata;

  assign s1_addr  = AW'(s1_item.col_idx);
  assign out_free = !m_tvalid || m_tready;
  assign s1_done  = s1_valid && (!s1_item.emit || out_free);
  assign s1_load  = !s1_valid || s1_done;
  assign pop      = queue_valid && s1_load && !clearing;

  p2bd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (AW'(queue_head.col_idx)),
    .rdata (rdata)
  );

  // The last write may have landed in the same cycle as the read: take it.
  assign acc = (fw_valid && fw_addr == s1_addr) ? fw_data : rdata;

  always_comb begin
    sum[7:0]   = acc[7:0]   + s1_item.red;
    sum[15:8]  = acc[15:8]  + s1_item.green;
    sum[23:16] = acc[23:16] + s1_item.blue;
    sum[31:24] = s1_item.alpha_en ? acc[31:24] + s1_item.alpha : '0;
  end

  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else begin
      we    = s1_done;
      waddr = s1_addr;
      wdata = s1_item.emit ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      fw_valid <= 1'b0;
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (we) begin
        fw_valid <= 1'b1;
      end
      if (s1_load) begin
        s1_valid <= pop;
      end
      if (s1_done && s1_item.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fw_addr <= waddr;
      fw_data <= wdata;
    end
    if (pop) begin
      s1_item <= queue_head;
    end
    if (s1_done && s1_item.emit) begin
      m_tdata <= sum;
      m_tlast <= s1_item.last;
    end
  end

  `P2BD_ASSERT_IMP(a_no_pop_in_clear, clearing, !pop && !s1_valid, "item taken during clear")
  `P2BD_ASSERT_NXT(a_stall_holds, s1_valid && !s1_done,
                   s1_valid && $stable(s1_item), "stalled accumulate lost")
  `P2BD_ASSERT_IMP(a_clear_write_only, clearing, we && wdata == '0, "clear sweep skipped")

endmodule

// File: hdl/power_of_two_box_downscaler.sv
// Top level of the power-of-two box downscaler.
//
// Pixels arrive on the s_ stream in raster order, one RGBA pixel per
// transaction. Each block of 2^f by 2^f pixels yields one reduced pixel on
// the m_ stream; m_tlast marks the last reduced pixel of the frame. Pixels of
// partial blocks at the right and bottom edges are dropped. Configuration
// (factor, width, height, alpha enable) is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while the stream is idle (not enforced).
// Throughput: one pixel per cycle unless m_tready stalls; the column
// accumulator memory takes one read and one write a cycle, with the last write forwarded.
// Output path: the bottom-right pixel of a block passes through the queue,
// the accumulate stage and the result register before showing on m_tvalid.
// Reset: the raster position returns to zero and a sweep over all MAX_WIDTH
// addresses zeroes the accumulator memory; s_tready stays low during the
// sweep, while configuration writes are taken as usual.
// Stalls: a low m_tready holds the result register; the queue between front
// and back keeps taking pixels until it fills, then s_tready drops.
module power_of_two_box_downscaler #(
  parameter int MAX_WIDTH   = p2bd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = p2bd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FACTOR  = p2bd_pkg::MAX_FACTOR_DEF,
  parameter int QUEUE_DEPTH = p2bd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [p2bd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [p2bd_pkg::CFG_W-1:0]     cfg_data,
  // Pixel input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [p2bd_pkg::PIX_W-1:0]     s_tdata,   // red_in, green_in, blue_in, alpha_in
  // Reduced pixel output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [p2bd_pkg::PIX_W-1:0]     m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic                           m_tlast    // frame_last
);

  import p2bd_pkg::*;

  logic       clearing;
  logic       push;
  logic       queue_full;
  logic       queue_valid;
  logic       pop;
  p2bd_item_t push_item;
  p2bd_item_t queue_head;

  // Classify pixels and track the raster position.
  p2bd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .clearing   (clearing),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  // Decouple front and back so each can stall on its own.
  p2bd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .head      (queue_head)
  );

  // Accumulate per output column and emit finished blocks.
  p2bd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .queue_valid (queue_valid),
    .queue_head  (queue_head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
